[hw/rtl/trms_pkg.sv]
package trms_pkg;

  // adc and accumulator widths
  localparam int ADC_BITS   = 12;
  localparam int COUNT_BITS = 16;
  localparam int SAMPLE_W   = 12;
  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam int SQR_W      = 2 * SAMPLE_W;
  localparam int SQ_W       = 40;
  localparam logic [SQ_W-1:0]       SQ_MAX    = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // back end widths
  localparam int WD_W     = 16;
  localparam int TOTAL_W  = 36;
  localparam int RMS_W    = 20;
  localparam int OUT_W    = 30;
  localparam int MA_W     = 20;
  localparam int MA_FRAC  = 10;
  localparam int MID_W    = 12;
  localparam int CYC_W    = 16;
  localparam int Q8_SHIFT = 16;
  localparam int NUM_W    = SQ_W + Q8_SHIFT;
  localparam int ROOT_W   = NUM_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int DVS_W    = (COUNT_BITS > WD_W) ? COUNT_BITS : WD_W;
  localparam int PROD_W   = TOTAL_W + MA_W;
  localparam int HALF_W   = TOTAL_W / 2;
  localparam int PP_W     = (TOTAL_W - HALF_W) + MA_W;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [RMS_W-1:0]   RMS_MAX   = '1;
  localparam logic [OUT_W-1:0]   OUT_MAX   = '1;

  // window queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // port widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [MID_W-1:0] MIDPOINT_RST = 12'd2047;
  localparam logic [CYC_W-1:0] CYCLES_RST   = 16'd1;
  localparam logic [MA_W-1:0]  MA_RST       = 20'd27054;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIDPOINT      = 4'd0,
    REG_SUPPRESS      = 4'd1,
    REG_WINDOW_CYCLES = 4'd2,
    REG_MA_PER_STEP   = 4'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MID_W-1:0] midpoint;
    logic             suppress_noise;
    logic [CYC_W-1:0] window_cycles;
    logic [MA_W-1:0]  ma_per_step;
  } cfg_t;

  // one closed window handed from front to back
  typedef struct packed {
    logic [SQ_W-1:0]       sq;
    logic [COUNT_BITS-1:0] cnt;
    logic                  sat;
  } win_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DVS_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

[hw/rtl/trms_div.sv]
module trms_div (
  input  logic                clk,
  input  logic                rst_n,
  input  trms_pkg::div_req_t  req,
  output trms_pkg::div_rsp_t  rsp
);
  import trms_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  // one restoring step per cycle, quotient bits shift into num_r
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
        num_r  <= req.num;
        rem_r  <= '0;
        dvs_r  <= req.dvs;
      end else if (busy_r) begin
        num_r <= {num_r[NUM_W-2:0], ge};
        rem_r <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

[hw/rtl/trms_fifo.sv]
module trms_fifo (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  trms_pkg::win_t                       push_win,
  input  logic                                 pop,
  output trms_pkg::win_t                       head,
  output logic                                 empty,
  output logic [trms_pkg::FIFO_CNT_W-1:0]      count
);
  import trms_pkg::*;

  win_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_win;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

[hw/rtl/trms_front.sv]
module trms_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  trms_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [trms_pkg::SAMPLE_W-1:0]        sample_first,
  input  logic [trms_pkg::SAMPLE_W-1:0]        sample_second,
  input  logic                                 window_end,
  input  logic [trms_pkg::FIFO_CNT_W-1:0]      q_count,
  output logic                                 q_push,
  output trms_pkg::win_t                       q_win
);
  import trms_pkg::*;

  logic [SAMPLE_W-1:0]   a;
  logic [SAMPLE_W-1:0]   b;
  logic [SAMPLE_W:0]     pair_sum;
  logic [SAMPLE_W-1:0]   value;
  logic [SAMPLE_W-1:0]   mag;
  logic                  accept;
  logic                  pending;

  logic                  s1_valid_r;
  logic                  s1_end_r;
  logic [SQR_W-1:0]      s1_sq_r;

  logic [SQ_W-1:0]       sq_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  cnt_room;
  logic [SQ_W:0]         sq_sum;
  logic [SQ_W-1:0]       sq_nxt;
  logic [COUNT_BITS-1:0] cnt_nxt;

  // accept only when a window close can still find a queue slot
  always_comb begin
    pending  = s1_valid_r & s1_end_r;
    in_ready = ({1'b0, q_count} + (FIFO_CNT_W+1)'(pending)) < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    accept   = in_valid & in_ready;
  end

  // sample select and offset magnitude
  always_comb begin
    a        = sample_first & ADC_MASK;
    b        = sample_second & ADC_MASK;
    pair_sum = {1'b0, a} + {1'b0, b};
    value    = cfg.suppress_noise ? pair_sum[SAMPLE_W:1] : a;
    mag      = (value >= cfg.midpoint) ? (value - cfg.midpoint) : (cfg.midpoint - value);
  end

  // stage 1: square
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_end_r <= window_end;
      s1_sq_r  <= SQR_W'(mag) * SQR_W'(mag);
    end
  end

  // stage 2: saturating window accumulation
  always_comb begin
    cnt_room = (cnt_r != COUNT_MAX);
    sq_sum   = {1'b0, sq_r} + (SQ_W+1)'(s1_sq_r);
    sq_nxt   = sq_r;
    cnt_nxt  = cnt_r;
    if (cnt_room) begin
      cnt_nxt = cnt_r + 1'b1;
      sq_nxt  = sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0];
    end
    q_push    = s1_valid_r & s1_end_r;
    q_win.sq  = sq_nxt;
    q_win.cnt = cnt_nxt;
    q_win.sat = (cnt_nxt == COUNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r  <= '0;
      cnt_r <= '0;
    end else if (s1_valid_r) begin
      if (s1_end_r) begin
        sq_r  <= '0;
        cnt_r <= '0;
      end else begin
        sq_r  <= sq_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

[hw/rtl/trms_back.sv]
module trms_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  trms_pkg::cfg_t                  cfg,
  input  logic                            q_empty,
  input  trms_pkg::win_t                  q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [trms_pkg::OUT_W-1:0]      current_ma_q8,
  output logic [trms_pkg::RMS_W-1:0]      last_window_rms,
  output logic                            count_saturated
);
  import trms_pkg::*;

  localparam int STEP_W = $clog2(ROOT_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_WIN,
    S_SQRT,
    S_ACC,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_SUM,
    S_DIV_GO,
    S_DIV_OUT,
    S_EMIT
  } state_t;

  state_t              state_r;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                sat_win_r;
  logic                sat_seen_r;
  logic [NUM_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [STEP_W-1:0]   step_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [WD_W-1:0]     wd_r;
  logic [RMS_W-1:0]    rms_r;
  logic [PP_W-1:0]     pp_r;
  logic [PROD_W-1:0]   prod_r;
  logic [OUT_W-1:0]    mean_r;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_mean_r;
  logic [RMS_W-1:0]    out_rms_r;
  logic                out_sat_r;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                take;
  logic [RMS_W-1:0]    rms_clip;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_nxt;
  logic [WD_W-1:0]     wd_inc;
  logic [WD_W-1:0]     wd_nxt;
  logic [CYC_W-1:0]    cyc_eff;
  logic [OUT_W-1:0]    mean_clip;
  logic                out_free;
  logic                emit;

  trms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // divider requests: window mean square, then the final mean
  always_comb begin
    q_pop         = (state_r == S_IDLE) && !q_empty;
    div_req.start = q_pop || (state_r == S_DIV_GO);
    if (state_r == S_DIV_GO) begin
      div_req.num = NUM_W'(prod_r[PROD_W-1:MA_FRAC]);
      div_req.dvs = DVS_W'(wd_r);
    end else begin
      div_req.num = {q_head.sq, Q8_SHIFT'(0)};
      div_req.dvs = (q_head.cnt == '0) ? DVS_W'(1) : DVS_W'(q_head.cnt);
    end
  end

  // square root step, window total and count, mean clip and output handshake
  always_comb begin
    rem_sh    = {rem_r[REM_W-3:0], rad_r[NUM_W-1 -: 2]};
    trial     = REM_W'({root_r, 2'b01});
    take      = rem_sh >= trial;
    rms_clip  = (root_r > ROOT_W'(RMS_MAX)) ? RMS_MAX : root_r[RMS_W-1:0];
    total_sum = {1'b0, total_r} + (TOTAL_W+1)'(rms_clip);
    total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    wd_inc    = wd_r + 1'b1;
    wd_nxt    = (wd_inc == '0) ? '1 : wd_inc;
    cyc_eff   = (cfg.window_cycles == '0) ? CYC_W'(1) : cfg.window_cycles;
    mean_clip = (div_rsp.quo[NUM_W-1:OUT_W] != '0) ? OUT_MAX : div_rsp.quo[OUT_W-1:0];
    out_free  = !out_valid_r || out_ready;
    emit      = (state_r == S_EMIT) && out_free;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sat_seen_r  <= 1'b0;
      total_r     <= '0;
      wd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result word valid flag
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            sat_win_r <= q_head.sat;
            state_r   <= S_DIV_WIN;
          end
        end
        S_DIV_WIN: begin
          if (div_rsp.done) begin
            rad_r   <= div_rsp.quo;
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= STEP_W'(ROOT_W - 1);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad_r  <= {rad_r[NUM_W-3:0], 2'b00};
          rem_r  <= take ? (rem_sh - trial) : rem_sh;
          root_r <= {root_r[ROOT_W-2:0], take};
          if (step_r == '0) begin
            state_r <= S_ACC;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_ACC: begin
          rms_r      <= rms_clip;
          total_r    <= total_nxt;
          wd_r       <= wd_nxt;
          sat_seen_r <= sat_seen_r | sat_win_r;
          state_r    <= (wd_nxt >= cyc_eff) ? S_MUL_LO : S_IDLE;
        end
        S_MUL_LO: begin
          pp_r    <= PP_W'(total_r[HALF_W-1:0]) * PP_W'(cfg.ma_per_step);
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_r  <= PROD_W'(pp_r);
          pp_r    <= PP_W'(total_r[TOTAL_W-1:HALF_W]) * PP_W'(cfg.ma_per_step);
          state_r <= S_MUL_SUM;
        end
        S_MUL_SUM: begin
          prod_r  <= prod_r + (PROD_W'(pp_r) << HALF_W);
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV_OUT;
        end
        S_DIV_OUT: begin
          if (div_rsp.done) begin
            mean_r  <= mean_clip;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_mean_r  <= mean_r;
            out_rms_r   <= rms_r;
            out_sat_r   <= sat_seen_r;
            total_r     <= '0;
            wd_r        <= '0;
            sat_seen_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign current_ma_q8   = out_mean_r;
  assign last_window_rms = out_rms_r;
  assign count_saturated = out_sat_r;

endmodule

[hw/rtl/true_rms_current_meter_top.sv]
// path: a closing word passes the two front stages, the window queue, a window divide, a square
//   root, a multiply in low, high and sum steps, and a second divide before its result leaves
// throughput: one sample word per cycle while the window queue has room; the back end works
//   on one closed window at a time, and a four-entry window queue absorbs bursts
// reset: rst_n synchronous active low; registers return to their defaults, accumulators clear
module true_rms_current_meter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [trms_pkg::IN_DATA_W-1:0]      in_tdata,   // sample_first, sample_second
  input  logic                                in_tlast,   // window_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [trms_pkg::OUT_DATA_W-1:0]     out_tdata,  // current_ma_q8, last_window_rms, pad
  output logic                                out_tuser,  // count_saturated
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [trms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [trms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import trms_pkg::*;

  cfg_t                  cfg_r;
  logic                  q_push;
  win_t                  q_win;
  logic                  q_pop;
  win_t                  q_head;
  logic                  q_empty;
  logic [FIFO_CNT_W-1:0] q_count;
  logic [OUT_W-1:0]      current_ma_q8;
  logic [RMS_W-1:0]      last_window_rms;
  logic                  count_saturated;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.midpoint       <= MIDPOINT_RST;
      cfg_r.suppress_noise <= 1'b0;
      cfg_r.window_cycles  <= CYCLES_RST;
      cfg_r.ma_per_step    <= MA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIDPOINT:      cfg_r.midpoint       <= cfg_data[MID_W-1:0];
        REG_SUPPRESS:      cfg_r.suppress_noise <= cfg_data[0];
        REG_WINDOW_CYCLES: cfg_r.window_cycles  <= cfg_data[CYC_W-1:0];
        REG_MA_PER_STEP:   cfg_r.ma_per_step    <= cfg_data[MA_W-1:0];
        default:           cfg_r                <= cfg_r;
      endcase
    end
  end

  trms_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .sample_first  (in_tdata[SAMPLE_W-1:0]),
    .sample_second (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .window_end    (in_tlast),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_win         (q_win)
  );

  trms_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_win (q_win),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  trms_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .current_ma_q8   (current_ma_q8),
    .last_window_rms (last_window_rms),
    .count_saturated (count_saturated)
  );

  // result word packing
  assign out_tdata = {(OUT_DATA_W - OUT_W - RMS_W)'(0), last_window_rms, current_ma_q8};
  assign out_tuser = count_saturated;

endmodule

[hw/rtl/trms_checker.sv]
module trms_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [trms_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                                out_tuser
);

  // a waiting result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // a waiting result word keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // reset withdraws any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  // the divide and root chain means no result shortly after reset
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rst_n, 16))
    else $error("result word too soon after reset");

endmodule

bind true_rms_current_meter_top trms_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[verif/true_rms_current_meter_top_test.sv]
module true_rms_current_meter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import trms_pkg::*;

  localparam int SETTLE_CYCLES  = 1000;
  localparam int RX_HOLD_CYCLES = 2000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_PCT       = 38;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_WINDOW    = 200;

  typedef struct {
    logic [OUT_W-1:0] current_ma;
    logic [RMS_W-1:0] window_rms;
    logic             saturated;
  } meter_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  true_rms_current_meter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // sample_first, sample_second
    .in_tlast   (in_tlast),   // window_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // current_ma_q8, last_window_rms, pad
    .out_tuser  (out_tuser),  // count_saturated
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // register copies
  logic [MID_W-1:0] mid_code;
  logic             avg_on;
  logic [CYC_W-1:0] set_size;
  logic [MA_W-1:0]  ma_scale;

  // accumulator copies
  logic [SQ_W-1:0]       sq_sum;
  logic [COUNT_BITS-1:0] win_count;
  logic [WD_W-1:0]       windows_closed;
  logic [TOTAL_W-1:0]    rms_sum;
  logic                  sat_flag;

  meter_result_t pending_results[$];
  meter_result_t want_res;
  meter_result_t got_res;

  int  mismatches = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  reg_writes = 0;
  int  quiet_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  bit  rx_held = 1'b0;
  event rx_hold_go;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bit-serial integer square root
  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // advance the meter state by one sample word, queue a result when a set closes
  task automatic meter_step(input logic [11:0] s1, input logic [11:0] s2, input logic close);
    logic [12:0]   pair_sum;
    logic [11:0]   level;
    logic [11:0]   mag;
    logic [63:0]   wide;
    logic [63:0]   root;
    logic [15:0]   n;
    logic [15:0]   cycles;
    meter_result_t res;
    pair_sum = {1'b0, s1} + {1'b0, s2};
    level = avg_on ? pair_sum[12:1] : s1;
    mag = (level >= mid_code) ? level - mid_code : mid_code - level;
    if (win_count != COUNT_MAX) begin
      win_count = win_count + 1'b1;
      if (win_count == COUNT_MAX) sat_flag = 1'b1;
      wide = 64'(sq_sum) + 64'(mag) * 64'(mag);
      sq_sum = (wide > 64'(SQ_MAX)) ? SQ_MAX : wide[SQ_W-1:0];
    end
    if (!close) return;
    // window close: rms in q.8 steps
    n = (win_count == '0) ? 16'd1 : 16'(win_count);
    root = 64'(int_sqrt((64'(sq_sum) << Q8_SHIFT) / 64'(n)));
    if (root > 64'(RMS_MAX)) root = 64'(RMS_MAX);
    wide = 64'(rms_sum) + root;
    rms_sum = (wide > 64'(TOTAL_MAX)) ? TOTAL_MAX : wide[TOTAL_W-1:0];
    sq_sum = '0;
    win_count = '0;
    if (windows_closed != '1) windows_closed = windows_closed + 1'b1;
    cycles = (set_size == '0) ? 16'd1 : set_size;
    if (windows_closed < cycles) return;
    // set close: scaled mean
    wide = (64'(rms_sum) * 64'(ma_scale)) / (64'(windows_closed) << MA_FRAC);
    res.current_ma = (wide > 64'(OUT_MAX)) ? OUT_MAX : wide[OUT_W-1:0];
    res.window_rms = root[RMS_W-1:0];
    res.saturated  = sat_flag;
    pending_results.push_back(res);
    rms_sum = '0;
    windows_closed = '0;
    sat_flag = 1'b0;
  endtask

  // offer one sample word, with random gaps ahead of it
  task automatic push_sample(input logic [11:0] s1, input logic [11:0] s2, input logic close);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s2, s1};
    in_tlast  <= close;
    do @(posedge clk); while (!in_tready);
    meter_step(s1, s2, close);
    samples_sent++;
  endtask

  task automatic push_window(input int len);
    for (int i = 0; i < len; i++) begin
      push_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)), i == len - 1);
    end
  endtask

  // stop sending, wait for all results and let the back end run dry
  task automatic wait_meter_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIDPOINT:      mid_code = data[MID_W-1:0];
      REG_SUPPRESS:      avg_on   = data[0];
      REG_WINDOW_CYCLES: set_size = data[CYC_W-1:0];
      REG_MA_PER_STEP:   ma_scale = data[MA_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic config_meter(input logic [MID_W-1:0] mid, input logic avg,
                              input logic [CYC_W-1:0] cyc, input logic [MA_W-1:0] ma);
    write_reg(REG_MIDPOINT, CFG_DATA_W'(mid));
    write_reg(REG_SUPPRESS, CFG_DATA_W'(avg));
    write_reg(REG_WINDOW_CYCLES, CFG_DATA_W'(cyc));
    write_reg(REG_MA_PER_STEP, CFG_DATA_W'(ma));
    cfg_valid <= 1'b0;
  endtask

  // reset defaults, field extremes, halving truncation, zero and extreme registers
  task automatic test_directed();
    push_sample(12'd0, 12'd4095, 1'b1);
    push_sample(12'd4095, 12'd0, 1'b1);
    push_sample(12'd2047, 12'd0, 1'b1);
    push_sample(12'd100, 12'd200, 1'b0);
    push_sample(12'd3000, 12'd5, 1'b0);
    push_sample(12'd2047, 12'd4095, 1'b1);
    wait_meter_idle();
    config_meter(12'd0, 1'b1, 16'd0, 20'hFFFFF);
    push_sample(12'd4095, 12'd4095, 1'b1);
    push_sample(12'd4095, 12'd0, 1'b1);
    push_sample(12'd1, 12'd0, 1'b1);
    push_sample(12'd4094, 12'd4095, 1'b0);
    push_sample(12'd0, 12'd0, 1'b1);
    wait_meter_idle();
    config_meter(12'd4095, 1'b0, 16'd3, 20'd0);
    push_sample(12'd0, 12'd1, 1'b1);
    push_sample(12'd4095, 12'd2, 1'b1);
    push_sample(12'd123, 12'd3, 1'b0);
    push_sample(12'd4000, 12'd4, 1'b1);
  endtask

  // set size lowered while windows are pending: result on the next close
  task automatic test_set_shrink();
    wait_meter_idle();
    config_meter(12'd2047, 1'b0, 16'hFFFF, 20'd27054);
    repeat (5) push_window($urandom_range(8, 1));
    wait_meter_idle();
    config_meter(12'd2047, 1'b0, 16'd2, 20'd27054);
    push_window(3);
  endtask

  // one long window sent back to back, then a short one in the same set
  task automatic test_long_window();
    wait_meter_idle();
    config_meter(12'd0, 1'b0, 16'd2, 20'hFFFFF);
    gaps_on = 1'b0;
    stalls_on <= 1'b0;
    push_window(LONG_WINDOW);
    push_window(3);
    gaps_on = 1'b1;
    stalls_on <= 1'b1;
  endtask

  // receiver holds off while single-window sets keep coming
  task automatic test_backpressure();
    wait_meter_idle();
    config_meter(12'd2047, 1'b0, 16'd1, 20'd27054);
    -> rx_hold_go;
    repeat (40) push_window(2);
  endtask

  task automatic test_random_sets(input int phases, input int words_per_phase);
    logic [MID_W-1:0] mid;
    logic [CYC_W-1:0] cyc;
    logic [MA_W-1:0]  ma;
    int               words;
    int               len;
    for (int p = 0; p < phases; p++) begin
      wait_meter_idle();
      case ($urandom_range(7))
        0:       mid = '0;
        1:       mid = '1;
        default: mid = MID_W'($urandom_range(4095));
      endcase
      cyc = ($urandom_range(9) == 0) ? '0 : CYC_W'($urandom_range(4, 1));
      case ($urandom_range(7))
        0:       ma = '0;
        1:       ma = '1;
        default: ma = MA_W'($urandom_range(20'hFFFFF));
      endcase
      config_meter(mid, 1'($urandom_range(1)), cyc, ma);
      words = 0;
      while (words < words_per_phase) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        push_window(len);
        words += len;
      end
    end
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.current_ma = out_tdata[OUT_W-1:0];
      got_res.window_rms = out_tdata[OUT_W+RMS_W-1:OUT_W];
      got_res.saturated  = out_tuser;
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result word", 64'd0, 64'(got_res.current_ma));
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.current_ma != want_res.current_ma)
          note_mismatch("current_ma_q8", 64'(want_res.current_ma), 64'(got_res.current_ma));
        if (got_res.window_rms != want_res.window_rms)
          note_mismatch("last_window_rms", 64'(want_res.window_rms), 64'(got_res.window_rms));
        if (got_res.saturated != want_res.saturated)
          note_mismatch("count_saturated", 64'(want_res.saturated), 64'(got_res.saturated));
      end
    end
  end

  // receiver ready with random stalls
  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else if (rx_held)
      out_tready <= 1'b0;
    else if (stalls_on)
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    else
      out_tready <= 1'b1;
  end

  // long receiver hold-off
  always begin
    @(rx_hold_go);
    rx_held <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_held <= 1'b0;
  end

  // watchdog on cycles with no word moving anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mid_code       = MIDPOINT_RST;
    avg_on         = 1'b0;
    set_size       = CYCLES_RST;
    ma_scale       = MA_RST;
    sq_sum         = '0;
    win_count      = '0;
    windows_closed = '0;
    rms_sum        = '0;
    sat_flag       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_set_shrink();
    test_long_window();
    test_backpressure();
    test_random_sets(6, 180);

    wait_meter_idle();
    $display("run covered %0d sample words, %0d register writes, %0d result words checked",
             samples_sent, reg_writes, results_seen);
    $display("directed extremes, set shrink, long window, receiver hold-off, random sets");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
